### src/meo_pkg.sv
// ----------------------------------------------------------------------------
// meo_pkg: shared types and constants for mecanum encoder odometry
// Fixed widths of the serial datapath, register indexes, reset values and the
// Q16.16 saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package meo_pkg;

  // Wheel rate magnitude (Q.24 rad/s), saturated to 2^56-1
  localparam int unsigned QuoW   = 56;
  // tick_to_rad_scale * 1e6
  localparam int unsigned KW     = 44;
  localparam int unsigned RpmW   = 28;
  // Signed wheel rate, pair sums, body sums, body sum magnitude
  localparam int unsigned WsW    = 57;
  localparam int unsigned PairW  = 58;
  localparam int unsigned SumW   = 59;
  localparam int unsigned MagW   = 58;
  // radius_quarter * inv_half_track_sum
  localparam int unsigned YawKW  = 40;
  localparam int unsigned RadW   = 16;
  localparam int unsigned CfgW   = 24;

  // 9.549297 in Q4.24
  localparam logic [RpmW-1:0] RpmPerRadQ24 = 28'd160210618;
  localparam logic [19:0]     UsPerS       = 20'd1000000;

  localparam logic [23:0] TickScaleRst = 24'd528818;
  localparam logic [15:0] RadQuartRst  = 16'd1049;
  localparam logic [23:0] InvTrackRst  = 24'd177604;

  typedef enum logic [1:0] {
    CFG_TICK_SCALE     = 2'd0,
    CFG_RADIUS_QUARTER = 2'd1,
    CFG_INV_TRACK      = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_PAIR,
    ST_SUM,
    ST_ABS,
    ST_SCALE,
    ST_OUT
  } state_e;

  // Sign and magnitude to signed 32-bit, clamped
  function automatic logic [31:0] sat_q16(input logic neg, input logic [MagW-1:0] mag);
    logic [31:0] low;
    low = mag[31:0];
    if (neg) begin
      if (mag > MagW'(64'h8000_0000)) return 32'h8000_0000;
      return 32'd0 - low;
    end
    if (mag > MagW'(64'h7FFF_FFFF)) return 32'h7FFF_FFFF;
    return low;
  endfunction

endpackage

`default_nettype wire

### src/mecanum_encoder_odometry_top.sv
// ----------------------------------------------------------------------------
// mecanum_encoder_odometry_top: wheel speeds and body velocities from encoders
// Datapath: serial tick-scale multiply, 56-step divide (skipped when the
//   quotient saturates), 40-step yaw multiply.
// Requests: one at a time; the first sample after reset is only stored and
//   gives no result, and a zero time step goes straight to the output state.
// Reset: asynchronous, active low; clears control and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_encoder_odometry_top #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] pos_front_left_i,
  input  wire logic signed [31:0] pos_front_right_i,
  input  wire logic signed [31:0] pos_rear_left_i,
  input  wire logic signed [31:0] pos_rear_right_i,
  input  wire logic [31:0]        stamp_us_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      rpm_front_left_o,
  output logic signed [31:0]      rpm_front_right_o,
  output logic signed [31:0]      rpm_rear_left_o,
  output logic signed [31:0]      rpm_rear_right_o,
  output logic signed [31:0]      vel_forward_o,
  output logic signed [31:0]      vel_lateral_o,
  output logic signed [31:0]      yaw_rate_o,
  output logic                    zero_interval_o
);

  import meo_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned NW = PW + KW;

  state_e state_q, state_d;

  logic [23:0]            scale_q;
  logic [RadW-1:0]        rq_q;
  logic [23:0]            ihts_q;

  logic signed [31:0]     pos_in [4];
  logic signed [PW-1:0]   cur [4];
  logic [PW-1:0]          prev_pos_q [4];
  logic [PW-1:0]          delta_q [4];
  logic [PW-1:0]          mag [4];
  logic [31:0]            prev_stamp_q;
  logic [31:0]            dt_in;
  logic [31:0]            dt_q;
  logic                   have_prev_q;
  logic                   zero_q;
  logic                   accept;
  logic                   div_start;
  logic                   scale_start;
  logic                   load;

  logic [KW-1:0]          k_scale;
  logic [YawKW-1:0]       yaw_k;

  logic [3:0]             mk_busy;
  logic [3:0]             dv_busy;
  logic [3:0]             rp_busy;
  logic [2:0]             bd_busy;
  logic [NW-1:0]          num [4];
  logic [QuoW-1:0]        quo [4];
  logic [QuoW+RpmW-1:0]   rpm_prod [4];

  logic signed [WsW-1:0]   ws_q [4];
  logic signed [PairW-1:0] pair_q [5];
  logic signed [SumW-1:0]  sum_q [3];
  logic [MagW-1:0]         sum_mag [3];
  logic [MagW+RadW-1:0]    vx_prod;
  logic [MagW+RadW-1:0]    vy_prod;
  logic [MagW+YawKW-1:0]   vz_prod;

  logic                    out_valid_q;
  logic [31:0]             rpm_q [4];
  logic [31:0]             vx_q;
  logic [31:0]             vy_q;
  logic [31:0]             vz_q;
  logic                    zi_q;

  assign pos_in[0] = pos_front_left_i;
  assign pos_in[1] = pos_front_right_i;
  assign pos_in[2] = pos_rear_left_i;
  assign pos_in[3] = pos_rear_right_i;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign dt_in   = stamp_us_i - prev_stamp_q;
  assign k_scale = KW'(scale_q) * KW'(UsPerS);
  assign yaw_k   = YawKW'(rq_q) * YawKW'(ihts_q);
  assign load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= TickScaleRst;
      rq_q    <= RadQuartRst;
      ihts_q  <= InvTrackRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICK_SCALE:     scale_q <= cfg_wdata_i;
        CFG_RADIUS_QUARTER: rq_q    <= cfg_wdata_i[RadW-1:0];
        CFG_INV_TRACK:      ihts_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) have_prev_q <= 1'b1;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    scale_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && have_prev_q) begin
          state_d = (dt_in == '0) ? ST_OUT : ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_MUL;
      ST_MUL: begin
        if (mk_busy == '0) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dv_busy == '0) state_d = ST_PAIR;
      end
      ST_PAIR: state_d = ST_SUM;
      ST_SUM:  state_d = ST_ABS;
      ST_ABS: begin
        scale_start = 1'b1;
        state_d     = ST_SCALE;
      end
      ST_SCALE: begin
        if (rp_busy == '0 && bd_busy == '0) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Wheel lanes: numerator, divide by the time step, rpm scaling
  for (genvar g = 0; g < 4; g++) begin : g_wheel
    assign cur[g] = PW'(pos_in[g]);
    assign mag[g] = delta_q[g][PW-1] ? (PW'(0) - delta_q[g]) : delta_q[g];

    meo_smul #(.AW(KW), .BW(PW)) u_num (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (state_q == ST_SETUP),
      .a_i     (k_scale),
      .b_i     (mag[g]),
      .busy_o  (mk_busy[g]),
      .prod_o  (num[g])
    );

    meo_sdiv #(.NW(NW)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (num[g]),
      .dt_i    (dt_q),
      .busy_o  (dv_busy[g]),
      .quo_o   (quo[g])
    );

    meo_smul #(.AW(QuoW), .BW(RpmW)) u_rpm (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (scale_start),
      .a_i     (quo[g]),
      .b_i     (RpmPerRadQ24),
      .busy_o  (rp_busy[g]),
      .prod_o  (rpm_prod[g])
    );
  end

  // Body velocities
  for (genvar k = 0; k < 3; k++) begin : g_abs
    assign sum_mag[k] = sum_q[k][SumW-1] ? MagW'(-sum_q[k]) : MagW'(sum_q[k]);
  end

  meo_smul #(.AW(MagW), .BW(RadW)) u_vx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .a_i     (sum_mag[0]),
    .b_i     (rq_q),
    .busy_o  (bd_busy[0]),
    .prod_o  (vx_prod)
  );

  meo_smul #(.AW(MagW), .BW(RadW)) u_vy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .a_i     (sum_mag[1]),
    .b_i     (rq_q),
    .busy_o  (bd_busy[1]),
    .prod_o  (vy_prod)
  );

  meo_smul #(.AW(MagW), .BW(YawKW)) u_vz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .a_i     (sum_mag[2]),
    .b_i     (yaw_k),
    .busy_o  (bd_busy[2]),
    .prod_o  (vz_prod)
  );

  // Sample history and intermediate sums
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        delta_q[i]    <= cur[i] - prev_pos_q[i];
        prev_pos_q[i] <= cur[i];
      end
      prev_stamp_q <= stamp_us_i;
      dt_q         <= dt_in;
      zero_q       <= (dt_in == '0);
    end
    if (state_q == ST_DIV) begin
      for (int i = 0; i < 4; i++) begin
        ws_q[i] <= delta_q[i][PW-1] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      end
    end
    if (state_q == ST_PAIR) begin
      pair_q[0] <= PairW'(ws_q[0]) + PairW'(ws_q[1]);
      pair_q[1] <= PairW'(ws_q[2]) + PairW'(ws_q[3]);
      pair_q[2] <= PairW'(ws_q[1]) - PairW'(ws_q[0]);
      pair_q[3] <= PairW'(ws_q[2]) - PairW'(ws_q[3]);
      pair_q[4] <= PairW'(ws_q[3]) - PairW'(ws_q[2]);
    end
    if (state_q == ST_SUM) begin
      sum_q[0] <= SumW'(pair_q[0]) + SumW'(pair_q[1]);
      sum_q[1] <= SumW'(pair_q[2]) + SumW'(pair_q[3]);
      sum_q[2] <= SumW'(pair_q[2]) + SumW'(pair_q[4]);
    end
  end

  // Output register; a zero time step forces all speeds to zero
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        rpm_q[i] <= zero_q ? '0 :
                    sat_q16(delta_q[i][PW-1], MagW'(rpm_prod[i][QuoW+RpmW-1:32]));
      end
      vx_q <= zero_q ? '0 : sat_q16(sum_q[0][SumW-1], MagW'(vx_prod[MagW+RadW-1:24]));
      vy_q <= zero_q ? '0 : sat_q16(sum_q[1][SumW-1], MagW'(vy_prod[MagW+RadW-1:24]));
      vz_q <= zero_q ? '0 : sat_q16(sum_q[2][SumW-1], vz_prod[MagW+YawKW-1:40]);
      zi_q <= zero_q;
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign rpm_front_left_o  = rpm_q[0];
  assign rpm_front_right_o = rpm_q[1];
  assign rpm_rear_left_o   = rpm_q[2];
  assign rpm_rear_right_o  = rpm_q[3];
  assign vel_forward_o     = vx_q;
  assign vel_lateral_o     = vy_q;
  assign yaw_rate_o        = vz_q;
  assign zero_interval_o   = zi_q;

endmodule

`default_nettype wire

### src/meo_smul.sv
// ----------------------------------------------------------------------------
// meo_smul: bit-serial shift-add multiplier
// Retires one bit of b per cycle, LSB first; the adder is only AW+1 bits wide.
// ----------------------------------------------------------------------------
`default_nettype none

module meo_smul #(
  parameter int unsigned AW = 44,
  parameter int unsigned BW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic                  busy_o,
  output logic [AW+BW-1:0]      prod_o
);

  localparam int unsigned CntW = (BW > 1) ? $clog2(BW) : 1;

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [AW-1:0]     a_q;
  logic [AW+BW-1:0]  acc_q;
  logic [AW:0]       sum;

  // Upper half accumulates a; lower half holds the unused bits of b
  assign sum = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CntW'(BW - 1)) busy_q <= 1'b0;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{AW{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[BW-1:1]};
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

### src/meo_sdiv.sv
// ----------------------------------------------------------------------------
// meo_sdiv: bit-serial restoring divider with saturated quotient
// Produces a 56-bit quotient one bit per cycle; a numerator whose quotient
// would not fit is detected up front and clamps to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module meo_sdiv #(
  parameter int unsigned NW = 76
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [NW-1:0]            num_i,
  input  wire logic [31:0]              dt_i,
  output logic                          busy_o,
  output logic [meo_pkg::QuoW-1:0]      quo_o
);

  import meo_pkg::*;

  localparam int unsigned NPW  = (NW > QuoW) ? NW : QuoW + 1;
  localparam int unsigned HW   = NPW - QuoW;
  localparam int unsigned CW   = (HW > 32) ? HW : 32;
  localparam int unsigned CntW = $clog2(QuoW);

  logic [NPW-1:0]  num_pad;
  logic [CW-1:0]   hi_ext;
  logic            hi_ge;
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     rem_q;
  logic [QuoW-1:0] quo_q;
  logic [32:0]     rem2;
  logic [32:0]     rem_sub;
  logic            ge;

  assign num_pad = NPW'(num_i);
  assign hi_ext  = CW'(num_pad[NPW-1:QuoW]);
  // Quotient overflows 56 bits exactly when the top part reaches the divisor
  assign hi_ge   = hi_ext >= CW'(dt_i);

  assign rem2    = {rem_q, quo_q[QuoW-1]};
  assign rem_sub = rem2 - {1'b0, dt_i};
  assign ge      = rem2 >= {1'b0, dt_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !hi_ge;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CntW'(QuoW - 1)) busy_q <= 1'b0;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= hi_ext[31:0];
      quo_q <= hi_ge ? '1 : num_pad[QuoW-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[31:0] : rem2[31:0];
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### src/meo_checker.sv
// ----------------------------------------------------------------------------
// meo_checker: port-level checks for mecanum encoder odometry
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module meo_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] rpm_front_left_o,
  input wire logic signed [31:0] rpm_front_right_o,
  input wire logic signed [31:0] rpm_rear_left_o,
  input wire logic signed [31:0] rpm_rear_right_o,
  input wire logic signed [31:0] vel_forward_o,
  input wire logic signed [31:0] vel_lateral_o,
  input wire logic signed [31:0] yaw_rate_o,
  input wire logic               zero_interval_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rpm_front_left_o) &&
      $stable(rpm_rear_right_o) && $stable(yaw_rate_o) && $stable(zero_interval_o))
    else $error("result changed while stalled");

  // A zero time step reports no motion
  a_zero_speeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_interval_o |->
      rpm_front_left_o == 32'sd0 && rpm_front_right_o == 32'sd0 &&
      rpm_rear_left_o == 32'sd0 && rpm_rear_right_o == 32'sd0 &&
      vel_forward_o == 32'sd0 && vel_lateral_o == 32'sd0 && yaw_rate_o == 32'sd0)
    else $error("speeds nonzero on zero interval");

  // A new result only appears as the block returns to taking requests
  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result raised while request still in progress");

  // Ready drops only after a request was offered
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("ready dropped without a request");

endmodule

bind mecanum_encoder_odometry_top meo_checker u_meo_checker (.*);

`default_nettype wire

### bench/mecanum_encoder_odometry_top_tb.sv
// ----------------------------------------------------------------------------
// mecanum_encoder_odometry_top_tb: self-checking bench for encoder odometry
// Streams encoder samples through the request channel under bursty traffic and
// receiver stalls, predicts wheel rpm and body velocities in the bench, and
// compares every result field by field across several register settings.
// ----------------------------------------------------------------------------
module mecanum_encoder_odometry_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import meo_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE      = 200;
  localparam int unsigned LONG_HOLD   = 500;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic [63:0] RPM_PER_RAD_Q24 = 64'd160210618;
  localparam logic [63:0] US_PER_SECOND   = 64'd1000000;
  localparam logic [63:0] RATE_MAX        = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [1:0]  CFG_IDX_SPARE   = 2'd3;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } stall_mode_e;

  // pos[0..3]: front left, front right, rear left, rear right
  typedef struct packed {
    logic [3:0][31:0] pos;
    logic [31:0]      stamp;
  } sample_t;

  typedef struct packed {
    logic [3:0][31:0] rpm;
    logic [31:0]      vel_fwd;
    logic [31:0]      vel_lat;
    logic [31:0]      yaw;
    logic             zero;
  } odometry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_wdata_i = '0;

  logic    in_valid_i = 1'b0;
  logic    in_ready_o;
  sample_t offer_q = '0;

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] rpm_front_left_o;
  logic signed [31:0] rpm_front_right_o;
  logic signed [31:0] rpm_rear_left_o;
  logic signed [31:0] rpm_rear_right_o;
  logic signed [31:0] vel_forward_o;
  logic signed [31:0] vel_lateral_o;
  logic signed [31:0] yaw_rate_o;
  logic               zero_interval_o;

  mecanum_encoder_odometry_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pos_front_left_i  (offer_q.pos[0]),
    .pos_front_right_i (offer_q.pos[1]),
    .pos_rear_left_i   (offer_q.pos[2]),
    .pos_rear_right_i  (offer_q.pos[3]),
    .stamp_us_i        (offer_q.stamp),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .rpm_front_left_o  (rpm_front_left_o),
    .rpm_front_right_o (rpm_front_right_o),
    .rpm_rear_left_o   (rpm_rear_left_o),
    .rpm_rear_right_o  (rpm_rear_right_o),
    .vel_forward_o     (vel_forward_o),
    .vel_lateral_o     (vel_lateral_o),
    .yaw_rate_o        (yaw_rate_o),
    .zero_interval_o   (zero_interval_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  sample_t   pending_samples[$];
  odometry_t expected_odometry[$];

  // Bench copy of the registers and of the stored sample
  logic [23:0]      tick_scale;
  logic [15:0]      radius_q;
  logic [23:0]      inv_track;
  logic [3:0][31:0] last_pos;
  logic [31:0]      last_stamp;
  logic             have_last;

  // Stimulus generator position, independent of the prediction
  logic [3:0][31:0] gen_pos = '0;
  logic [31:0]      gen_stamp = '0;

  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned settings_used = 0;
  int unsigned odo_seen = 0;
  int unsigned zero_seen = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------- prediction

  function automatic logic [31:0] clamp_q16(input logic neg, input logic [127:0] mag);
    if (neg) begin
      if (mag > 128'h8000_0000) return 32'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Sign-magnitude product, truncated toward zero, then clamped
  function automatic logic [31:0] scaled_q16(input logic signed [63:0] v, input logic [63:0] k,
                                             input int unsigned sh);
    logic         neg;
    logic [63:0]  mag;
    logic [127:0] prod;
    neg  = v[63];
    mag  = neg ? 64'd0 - v : v;
    prod = (128'(mag) * 128'(k)) >> sh;
    return clamp_q16(neg, prod);
  endfunction

  // Signed wheel rate in Q.24 rad/s, magnitude saturated to 56 bits
  function automatic logic signed [63:0] wheel_speed(input logic [31:0] cur,
                                                     input logic [31:0] prev,
                                                     input logic [31:0] dt);
    logic [31:0]  delta;
    logic         neg;
    logic [31:0]  mag;
    logic [127:0] quo;
    logic [63:0]  rate;
    delta = cur - prev;
    neg   = delta[31];
    mag   = neg ? 32'd0 - delta : delta;
    quo   = (128'(mag) * 128'(tick_scale) * 128'(US_PER_SECOND)) / 128'(dt);
    rate  = (quo > 128'(RATE_MAX)) ? RATE_MAX : quo[63:0];
    return neg ? -$signed(rate) : $signed(rate);
  endfunction

  task automatic predict_odometry(input sample_t s);
    odometry_t          r;
    logic [31:0]        dt;
    logic signed [63:0] w[4];
    logic signed [63:0] sx, sy, sz;
    if (!have_last) begin
      last_pos   = s.pos;
      last_stamp = s.stamp;
      have_last  = 1'b1;
      return;
    end
    dt = s.stamp - last_stamp;
    r  = '0;
    if (dt == 32'd0) begin
      r.zero = 1'b1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        w[i]     = wheel_speed(s.pos[i], last_pos[i], dt);
        r.rpm[i] = scaled_q16(w[i], RPM_PER_RAD_Q24, 32);
      end
      sx = w[0] + w[1] + w[2] + w[3];
      sy = -w[0] + w[1] + w[2] - w[3];
      sz = -w[0] + w[1] - w[2] + w[3];
      r.vel_fwd = scaled_q16(sx, 64'(radius_q), 24);
      r.vel_lat = scaled_q16(sy, 64'(radius_q), 24);
      r.yaw     = scaled_q16(sz, 64'(radius_q) * 64'(inv_track), 40);
    end
    expected_odometry.push_back(r);
    last_pos   = s.pos;
    last_stamp = s.stamp;
  endtask

  // ---------------------------------------------------------------- sender

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      offer_q    <= '0;
      burst_left <= 1;
      gap_left   <= 0;
      have_last  = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_odometry(offer_q);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          offer_q    <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;

  // Two long hold-offs, triggered by result count, back up the request side
  always @(posedge clk_i or negedge rst_ni) begin : result_stall
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_cycle    <= 0;
      hold_left   <= 0;
      holds_done  <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (holds_done < 2 && odo_seen >= ((holds_done == 0) ? 300 : 1000)) begin
        hold_left   <= LONG_HOLD;
        holds_done  <= holds_done + 1;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode_e'(rx_cycle[9:8]))
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= rx_cycle[2];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0d ns: %s expected %h, got %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    odometry_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.rpm[0]  = rpm_front_left_o;
      got.rpm[1]  = rpm_front_right_o;
      got.rpm[2]  = rpm_rear_left_o;
      got.rpm[3]  = rpm_rear_right_o;
      got.vel_fwd = vel_forward_o;
      got.vel_lat = vel_lateral_o;
      got.yaw     = yaw_rate_o;
      got.zero    = zero_interval_o;
      if (expected_odometry.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0d ns: result with none expected, expected nothing, got %h", $time, got);
      end else begin
        want = expected_odometry.pop_front();
        compare_field("rpm_front_left", want.rpm[0], got.rpm[0]);
        compare_field("rpm_front_right", want.rpm[1], got.rpm[1]);
        compare_field("rpm_rear_left", want.rpm[2], got.rpm[2]);
        compare_field("rpm_rear_right", want.rpm[3], got.rpm[3]);
        compare_field("vel_forward", want.vel_fwd, got.vel_fwd);
        compare_field("vel_lateral", want.vel_lat, got.vel_lat);
        compare_field("yaw_rate", want.yaw, got.yaw);
        compare_field("zero_interval", 32'(want.zero), 32'(got.zero));
      end
      odo_seen  <= odo_seen + 1;
      zero_seen <= zero_seen + 32'(got.zero);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0d ns: timeout after %0d cycles", $time, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_TICK_SCALE:     tick_scale = data;
      CFG_RADIUS_QUARTER: radius_q   = data[15:0];
      CFG_INV_TRACK:      inv_track  = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_gains(input logic [23:0] tick, input logic [23:0] rad,
                             input logic [23:0] inv);
    write_reg(CFG_TICK_SCALE, tick);
    write_reg(CFG_RADIUS_QUARTER, rad);
    write_reg(CFG_INV_TRACK, inv);
    settings_used++;
  endtask

  // Hold until the block is idle with nothing outstanding
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid_i || expected_odometry.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic queue_sample(input logic [31:0] fl, input logic [31:0] fr,
                              input logic [31:0] rl, input logic [31:0] rr,
                              input logic [31:0] stamp);
    sample_t s;
    s.pos   = {rr, rl, fr, fl};
    s.stamp = stamp;
    pending_samples.push_back(s);
    gen_pos   = s.pos;
    gen_stamp = stamp;
    samples_sent++;
  endtask

  function automatic logic [31:0] tick_step(input int unsigned span);
    logic [31:0] mag;
    mag = $urandom_range(0, 32'd1 << span);
    return ($urandom_range(0, 1) != 0) ? 32'd0 - mag : mag;
  endfunction

  // Mostly steady motion; the rest zero steps, short-interval spikes and noise
  task automatic queue_random(input int count);
    sample_t     s;
    int unsigned kind;
    int unsigned span;
    repeat (count) begin
      kind    = $urandom_range(0, 15);
      span    = $urandom_range(0, 20);
      s.pos   = gen_pos;
      s.stamp = gen_stamp;
      if (kind < 11) begin
        for (int i = 0; i < 4; i++) s.pos[i] = gen_pos[i] + tick_step(span);
        s.stamp = gen_stamp + $urandom_range(1, 32'd1 << $urandom_range(0, 24));
      end else if (kind == 11) begin
        for (int i = 0; i < 4; i++) s.pos[i] = gen_pos[i] + tick_step(span);
      end else if (kind == 12) begin
        for (int i = 0; i < 4; i++) s.pos[i] = $urandom;
        s.stamp = gen_stamp + $urandom_range(1, 8);
      end else begin
        for (int i = 0; i < 4; i++) s.pos[i] = $urandom;
        s.stamp = $urandom;
      end
      queue_sample(s.pos[0], s.pos[1], s.pos[2], s.pos[3], s.stamp);
    end
  endtask

  initial begin
    tick_scale    = 24'd528818;
    radius_q      = 16'd1049;
    inv_track     = 24'd177604;
    settings_used = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples on the reset gains
    queue_sample(0, 0, 0, 0, 1000);
    queue_sample(0, 0, 0, 0, 1000);
    queue_sample(100, 100, 100, 100, 2000);
    queue_sample(0, 200, 200, 0, 3000);
    queue_sample(-50, 250, 150, 50, 4000);
    queue_sample(32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 32'h7FFF_FFF0, 5000);
    queue_sample(32'h8000_0010, 32'h8000_0010, 32'h8000_0010, 32'h8000_0010, 6000);
    queue_sample(32'h8000_0010, 32'h8000_0010, 32'h8000_0010, 32'h8000_0010, 32'hFFFF_FFF0);
    queue_sample(32'h8000_0015, 32'h8000_000B, 32'h8000_0015, 32'h8000_000B, 32'h0000_0010);
    queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 11);
    queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 12);
    queue_sample(0, 0, 0, 0, 13);
    queue_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 12);
    queue_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 11);
    queue_sample(32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 1, 10);
    queue_sample(32'h8000_0002, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 0, 10);
    queue_random(250);
    drain();

    apply_gains(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    queue_random(150);
    drain();

    // Zero gains, plus a write to the unused index that must change nothing
    apply_gains(24'h00_0000, 24'h00_0000, 24'h00_0000);
    write_reg(CFG_IDX_SPARE, 24'($urandom));
    queue_random(60);
    drain();

    apply_gains(24'hFF_FFFF, 24'h00_0001, 24'h00_0001);
    queue_random(150);
    drain();

    repeat (5) begin
      apply_gains(24'($urandom), 24'($urandom), 24'($urandom));
      queue_random(200);
      drain();
    end

    if (expected_odometry.size() != 0) begin
      mismatches++;
      $display("%0d ns: %0d results still expected, got none", $time,
               expected_odometry.size());
    end
    $display("Ran %0d encoder samples over %0d gain settings with bursty requests and stalls",
             samples_sent, settings_used);
    $display("Checked %0d odometry results, %0d of them zero-interval; %0d field mismatches",
             odo_seen, zero_seen, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
src/meo_pkg.sv
src/meo_smul.sv
src/meo_sdiv.sv
src/mecanum_encoder_odometry_top.sv
src/meo_checker.sv
bench/mecanum_encoder_odometry_top_tb.sv
